>>> sv/mipmap_box_downsample_core_defines.svh
// Assertion macros for the mip level downsampler RTL, included by mbd_out.
// Include with the bare file name; no other dependencies.
`ifndef MIPMAP_BOX_DOWNSAMPLE_CORE_DEFINES_SVH
`define MIPMAP_BOX_DOWNSAMPLE_CORE_DEFINES_SVH

// Plain property, checked on every rising edge outside reset.
`define MBD_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in this cycle implies a consequence in the next one.
`define MBD_ASSERT_NEXT(label, clk, rst_n, cond, nxt, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) else $error(msg);

`endif

>>> sv/mbd_pkg.sv
// Shared constants, types and codes for the 2x2 box mip downsampler.
// No dependencies; used by every module of the block.
package mbd_pkg;

	localparam int MAX_WIDTH = 4096;
	localparam int SUM_DEPTH = MAX_WIDTH / 2;
	localparam int COL_W     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int ADDR_W    = (SUM_DEPTH > 1) ? $clog2(SUM_DEPTH) : 1;
	localparam int ROW_W     = 16;
	localparam int WREG_W    = 13;
	localparam int HREG_W    = 16;

	localparam int NUM_LANES = 4;
	localparam int CH_W      = 8;
	localparam int RP_W      = 10;  // up to three pixels along a row
	localparam int CS_W      = 12;  // up to nine pixels in a block

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 4'd1;

	// reciprocal constants: floor(x/3) exact for 12-bit sums, floor(x/9) for nine-pixel block sums
	localparam int RECIP3    = 2731;
	localparam int RECIP3_SH = 13;
	localparam int RECIP9    = 1821;
	localparam int RECIP9_SH = 14;
	localparam int PROD_W    = 24;

	typedef enum logic [2:0] {
		DIV1,
		DIV2,
		DIV3,
		DIV4,
		DIV6,
		DIV9
	} div_t;

	// decode of the pixel at the input port
	typedef struct packed {
		logic              col_end;
		logic              first_row;
		logic              emit;
		logic              frame_end;
		logic [ADDR_W-1:0] addr;
		div_t              div;
	} dec_t;

	// control travelling alongside the lane pipeline
	typedef struct packed {
		logic              valid;
		logic              first_row;
		logic              emit;
		logic              frame_end;
		logic [ADDR_W-1:0] addr;
		div_t              div;
	} pipe_t;

	typedef struct packed {
		logic [NUM_LANES*CH_W-1:0] data;
		logic                      last;
	} beat_t;

endpackage

>>> sv/mbd_ctrl.sv
// Frame sequencer: size registers, raster position counters, block decode
// and the control side of the lane pipeline. Depends on mbd_pkg.
module mbd_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           acc,
	input  logic                           en,
	input  logic                           cfg_valid,
	input  logic [mbd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mbd_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                           restart,
	output mbd_pkg::dec_t                  dec,
	output mbd_pkg::pipe_t                 p_s1,
	output mbd_pkg::pipe_t                 p_s2
);

	logic [mbd_pkg::WREG_W-1:0] src_width_q;
	logic [mbd_pkg::HREG_W-1:0] src_height_q;
	logic [mbd_pkg::COL_W-1:0]  col_q;
	logic [mbd_pkg::ROW_W-1:0]  row_q;

	logic [31:0]                w_full, h_full, mw_full, mh_full;
	logic [mbd_pkg::COL_W-1:0]  wm1;
	logic [mbd_pkg::ADDR_W-1:0] mwm1;
	logic [mbd_pkg::ROW_W-1:0]  hm1;
	logic [mbd_pkg::ROW_W-2:0]  mhm1;
	logic                       w_is1, h_is1, w_odd, h_odd;

	logic [mbd_pkg::COL_W-1:0]  oc_raw;
	logic [mbd_pkg::ROW_W-1:0]  orow_raw;
	logic [mbd_pkg::ADDR_W-1:0] oc;
	logic [mbd_pkg::ROW_W-2:0]  orow;
	logic                       orow_clamp, row_end, oc_last, orow_last;
	logic [1:0]                 f_col, f_row;

	assign restart = cfg_valid &&
		(cfg_index == mbd_pkg::REG_SRC_WIDTH || cfg_index == mbd_pkg::REG_SRC_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= mbd_pkg::WREG_W'(1);
			src_height_q <= mbd_pkg::HREG_W'(1);
		end else if (cfg_valid) begin
			if (cfg_index == mbd_pkg::REG_SRC_WIDTH)
				src_width_q <= cfg_data[mbd_pkg::WREG_W-1:0];
			if (cfg_index == mbd_pkg::REG_SRC_HEIGHT)
				src_height_q <= cfg_data[mbd_pkg::HREG_W-1:0];
		end
	end

	// effective sizes: zero reads as one, width capped at the store size
	always_comb begin
		w_full = 32'(src_width_q);
		if (w_full == 32'd0)
			w_full = 32'd1;
		if (w_full > 32'(mbd_pkg::MAX_WIDTH))
			w_full = 32'(mbd_pkg::MAX_WIDTH);
		h_full = 32'(src_height_q);
		if (h_full == 32'd0)
			h_full = 32'd1;
		mw_full = (w_full > 32'd1) ? (w_full >> 1) : 32'd1;
		mh_full = (h_full > 32'd1) ? (h_full >> 1) : 32'd1;
		wm1   = mbd_pkg::COL_W'(w_full - 32'd1);
		mwm1  = mbd_pkg::ADDR_W'(mw_full - 32'd1);
		hm1   = mbd_pkg::ROW_W'(h_full - 32'd1);
		mhm1  = (mbd_pkg::ROW_W-1)'(mh_full - 32'd1);
		w_is1 = (w_full == 32'd1);
		h_is1 = (h_full == 32'd1);
		w_odd = w_full[0];
		h_odd = h_full[0];
	end

	// block decode of the pixel at the port
	always_comb begin
		oc_raw   = col_q >> 1;
		orow_raw = row_q >> 1;
		oc = (oc_raw > mbd_pkg::COL_W'(mwm1)) ? mwm1 : mbd_pkg::ADDR_W'(oc_raw);
		orow_clamp = (orow_raw > mbd_pkg::ROW_W'(mhm1));
		orow = orow_clamp ? mhm1 : orow_raw[mbd_pkg::ROW_W-2:0];
		oc_last   = (oc == mwm1);
		orow_last = (orow == mhm1);
		row_end = (row_q == hm1) || (row_q[0] && (orow_raw < mbd_pkg::ROW_W'(mhm1)));

		dec.col_end   = (col_q == wm1) || (col_q[0] && (oc_raw < mbd_pkg::COL_W'(mwm1)));
		dec.first_row = !row_q[0] && !orow_clamp;
		dec.emit      = dec.col_end && row_end && !(w_is1 && h_is1);
		dec.frame_end = oc_last && orow_last;
		dec.addr      = oc;

		f_col = w_is1 ? 2'd1 : ((oc_last && w_odd) ? 2'd3 : 2'd2);
		f_row = h_is1 ? 2'd1 : ((orow_last && h_odd) ? 2'd3 : 2'd2);
		unique case ({f_col, f_row})
			4'b0101:         dec.div = mbd_pkg::DIV1;
			4'b0110, 4'b1001: dec.div = mbd_pkg::DIV2;
			4'b0111, 4'b1101: dec.div = mbd_pkg::DIV3;
			4'b1010:         dec.div = mbd_pkg::DIV4;
			4'b1011, 4'b1110: dec.div = mbd_pkg::DIV6;
			4'b1111:         dec.div = mbd_pkg::DIV9;
			default:         dec.div = mbd_pkg::DIV1;
		endcase
	end

	// raster position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (col_q == wm1) begin
				col_q <= '0;
				row_q <= (row_q == hm1) ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// only column-end pixels enter the pipeline; only block ends reach stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_s1 <= '0;
			p_s2 <= '0;
		end else if (en) begin
			p_s1.valid     <= acc && dec.col_end;
			p_s1.first_row <= dec.first_row;
			p_s1.emit      <= dec.emit;
			p_s1.frame_end <= dec.frame_end;
			p_s1.addr      <= dec.addr;
			p_s1.div       <= dec.div;
			p_s2.valid     <= p_s1.valid && p_s1.emit;
			p_s2.first_row <= p_s1.first_row;
			p_s2.emit      <= p_s1.emit;
			p_s2.frame_end <= p_s1.frame_end;
			p_s2.addr      <= p_s1.addr;
			p_s2.div       <= p_s1.div;
		end
	end

endmodule

>>> sv/mbd_lane.sv
// One colour channel: row partial sum, column sum store with bypass,
// and division by the block pixel count. Depends on mbd_pkg.
module mbd_lane (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      acc,
	input  logic                      restart,
	input  mbd_pkg::dec_t             dec,
	input  mbd_pkg::pipe_t            p_s1,
	input  mbd_pkg::pipe_t            p_s2,
	input  logic [mbd_pkg::CH_W-1:0]  px,
	output logic [mbd_pkg::CH_W-1:0]  q
);

	logic [mbd_pkg::CS_W-1:0]   mem [mbd_pkg::SUM_DEPTH];
	logic [mbd_pkg::RP_W-1:0]   rp_q, rp_new, rp_s1;
	logic [mbd_pkg::CS_W-1:0]   rd_s1, base, sum_s1, sum_s2;
	logic                       fwd_v_q;
	logic [mbd_pkg::ADDR_W-1:0] fwd_a_q;
	logic [mbd_pkg::CS_W-1:0]   fwd_d_q;
	logic [mbd_pkg::PROD_W-1:0] prod3, prod9;

	assign rp_new = rp_q + mbd_pkg::RP_W'(px);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rp_q <= '0;
		else if (restart)
			rp_q <= '0;
		else if (acc)
			rp_q <= dec.col_end ? '0 : rp_new;
	end

	always_ff @(posedge clk) begin
		if (acc && dec.col_end)
			rp_s1 <= rp_new;
	end

	// column store: read on entry, written back from stage 1
	always_ff @(posedge clk) begin
		if (acc && dec.col_end)
			rd_s1 <= mem[dec.addr];
		if (en && p_s1.valid)
			mem[p_s1.addr] <= sum_s1;
	end

	// last write back, covers the read that raced it on the same edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			fwd_v_q <= 1'b0;
		else if (en && p_s1.valid)
			fwd_v_q <= 1'b1;
	end

	always_ff @(posedge clk) begin
		if (en && p_s1.valid) begin
			fwd_a_q <= p_s1.addr;
			fwd_d_q <= sum_s1;
		end
	end

	assign base   = (fwd_v_q && fwd_a_q == p_s1.addr) ? fwd_d_q : rd_s1;
	assign sum_s1 = p_s1.first_row ? mbd_pkg::CS_W'(rp_s1) : base + mbd_pkg::CS_W'(rp_s1);

	always_ff @(posedge clk) begin
		if (en && p_s1.valid)
			sum_s2 <= sum_s1;
	end

	assign prod3 = mbd_pkg::PROD_W'(sum_s2) * mbd_pkg::PROD_W'(mbd_pkg::RECIP3);
	assign prod9 = mbd_pkg::PROD_W'(sum_s2) * mbd_pkg::PROD_W'(mbd_pkg::RECIP9);

	always_comb begin
		unique case (p_s2.div)
			mbd_pkg::DIV1: q = sum_s2[mbd_pkg::CH_W-1:0];
			mbd_pkg::DIV2: q = sum_s2[1 +: mbd_pkg::CH_W];
			mbd_pkg::DIV4: q = sum_s2[2 +: mbd_pkg::CH_W];
			mbd_pkg::DIV3: q = prod3[mbd_pkg::RECIP3_SH +: mbd_pkg::CH_W];
			mbd_pkg::DIV6: q = prod3[mbd_pkg::RECIP3_SH+1 +: mbd_pkg::CH_W];
			mbd_pkg::DIV9: q = prod9[mbd_pkg::RECIP9_SH +: mbd_pkg::CH_W];
			default:       q = sum_s2[mbd_pkg::CH_W-1:0];
		endcase
	end

endmodule

>>> sv/mbd_out.sv
// Merge of the lane results into output beats, held in a two-entry buffer
// that also sets the pipeline advance. Depends on mbd_pkg and the macro header.
`include "mipmap_box_downsample_core_defines.svh"

module mbd_out (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	input  logic [mbd_pkg::NUM_LANES-1:0][mbd_pkg::CH_W-1:0] lane_q,
	input  logic                                   frame_end,
	output logic                                   en,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [mbd_pkg::NUM_LANES*mbd_pkg::CH_W-1:0] m_tdata,
	output logic                                   m_tlast
);

	localparam logic [1:0] FULL = 2'd2;

	mbd_pkg::beat_t ent_q [2];
	logic           wr_ptr_q, rd_ptr_q;
	logic [1:0]     cnt_q;
	logic           push, pop;

	assign en       = (cnt_q != FULL);
	assign push     = en && in_valid;
	assign m_tvalid = (cnt_q != 2'd0);
	assign pop      = m_tvalid && m_tready;
	assign m_tdata  = ent_q[rd_ptr_q].data;
	assign m_tlast  = ent_q[rd_ptr_q].last;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q].data <= lane_q;
			ent_q[wr_ptr_q].last <= frame_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	`MBD_ASSERT(a_no_overfill, clk, arst_n, !push || cnt_q != FULL, "beat pushed into full buffer")
	`MBD_ASSERT_NEXT(a_cnt_up, clk, arst_n, push && !pop, cnt_q == $past(cnt_q) + 2'd1, "count did not rise")
	`MBD_ASSERT_NEXT(a_cnt_dn, clk, arst_n, pop && !push, cnt_q == $past(cnt_q) - 2'd1, "count did not fall")

endmodule

>>> sv/mipmap_box_downsample_core.sv
// Path: a pixel that closes a block passes the stage 1 and stage 2 registers, then
// is written into the output buffer, which drives the output port.
// Throughput: one pixel per clock; s_tready falls only while the two-beat output
// buffer is full, and the per-lane column store is read and written once per clock.
// Reset: counters, partial sums and sizes (1x1) cleared; column store not cleared.
module mipmap_box_downsample_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [31:0]                    s_tdata,    // red_in, green_in, blue_in, alpha_in
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [31:0]                    m_tdata,    // red_out, green_out, blue_out, alpha_out
	output logic                           m_tlast,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [mbd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mbd_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic           en, acc, restart;
	mbd_pkg::dec_t  dec;
	mbd_pkg::pipe_t p_s1, p_s2;
	logic [mbd_pkg::NUM_LANES-1:0][mbd_pkg::CH_W-1:0] lane_q;

	assign cfg_ready = 1'b1;
	assign s_tready  = en;
	assign acc       = s_tvalid && en;

	mbd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (acc),
		.en        (en),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.restart   (restart),
		.dec       (dec),
		.p_s1      (p_s1),
		.p_s2      (p_s2)
	);

	for (genvar i = 0; i < mbd_pkg::NUM_LANES; i++) begin : g_lane
		mbd_lane u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.acc     (acc),
			.restart (restart),
			.dec     (dec),
			.p_s1    (p_s1),
			.p_s2    (p_s2),
			.px      (s_tdata[i*mbd_pkg::CH_W +: mbd_pkg::CH_W]),
			.q       (lane_q[i])
		);
	end

	mbd_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (p_s2.valid),
		.lane_q    (lane_q),
		.frame_end (p_s2.frame_end),
		.en        (en),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

>>> tb/mipmap_box_downsample_core_tb.sv
// Self-checking bench for the 2x2 box mip level downsampler core.
// Depends on mbd_pkg and mipmap_box_downsample_core; reads nothing at run time.
// Directed table first, then random image sizes with stalls on both streams.
`timescale 1ns / 1ps

module tb;

	localparam int LONG_STALL   = 400;   // receiver hold-off, in cycles
	localparam int STALL_LIMIT  = 4000;  // cycles without any beat before giving up
	localparam int DRAIN_CYCLES = 6;     // pipeline depth plus margin
	localparam int ITEMS        = 1400;
	localparam int NPLAN        = 34;
	localparam int FIRST_SPARE_REG = 2;
	localparam int LAST_SPARE_REG  = (1 << mbd_pkg::CFG_IDX_W) - 1;
	localparam logic [mbd_pkg::CFG_IDX_W-1:0] REG_SPARE = 4'd7;

	typedef struct packed {
		logic [mbd_pkg::NUM_LANES-1:0][mbd_pkg::CH_W-1:0] px;  // red in the lowest byte
		logic                                             last;
	} mip_px_t;

	typedef enum logic [1:0] {ROW_CFG, ROW_PIX, ROW_PIX_NONE, ROW_PIX_OUT} plan_kind_t;

	typedef struct packed {
		plan_kind_t                     kind;
		logic [mbd_pkg::CFG_IDX_W-1:0]  idx;
		logic [mbd_pkg::CFG_DATA_W-1:0] val;
		logic [31:0]                    pix;
		mip_px_t                        want;
	} plan_row_t;

	// idx/val are ignored on pixel rows; want is used only on ROW_PIX_OUT rows
	localparam plan_row_t PLAN [NPLAN] = '{
		'{ROW_PIX_NONE, '0, '0, 32'h00000000, '{32'h0, 1'b0}},  // 1x1 after reset
		'{ROW_CFG, mbd_pkg::REG_SRC_WIDTH, 16'd2, 32'h0, '{32'h0, 1'b0}},
		'{ROW_CFG, mbd_pkg::REG_SRC_HEIGHT, 16'd2, 32'h0, '{32'h0, 1'b0}},
		'{ROW_PIX_NONE, '0, '0, 32'hFFFFFFFF, '{32'h0, 1'b0}},
		'{ROW_PIX_NONE, '0, '0, 32'hFFFFFFFF, '{32'h0, 1'b0}},
		'{ROW_PIX_NONE, '0, '0, 32'hFFFFFFFF, '{32'h0, 1'b0}},
		'{ROW_PIX_OUT, '0, '0, 32'hFFFFFFFF, '{32'hFFFFFFFF, 1'b1}},
		// truncation, with a write to a spare index mid-block (no restart)
		'{ROW_PIX_NONE, '0, '0, 32'hFF030201, '{32'h0, 1'b0}},
		'{ROW_PIX_NONE, '0, '0, 32'hFF020100, '{32'h0, 1'b0}},
		'{ROW_CFG, REG_SPARE, 16'hFFFF, 32'h0, '{32'h0, 1'b0}},
		'{ROW_PIX_NONE, '0, '0, 32'hFE000000, '{32'h0, 1'b0}},
		'{ROW_PIX_OUT, '0, '0, 32'hFF000000, '{32'hFE010000, 1'b1}},
		// odd both ways: one 3x3 block
		'{ROW_CFG, mbd_pkg::REG_SRC_WIDTH, 16'd3, 32'h0, '{32'h0, 1'b0}},
		'{ROW_CFG, mbd_pkg::REG_SRC_HEIGHT, 16'd3, 32'h0, '{32'h0, 1'b0}},
		'{ROW_PIX, '0, '0, 32'h8001FF7F, '{32'h0, 1'b0}},
		'{ROW_PIX, '0, '0, 32'h7FFE0080, '{32'h0, 1'b0}},
		'{ROW_PIX, '0, '0, 32'h01020304, '{32'h0, 1'b0}},
		'{ROW_PIX, '0, '0, 32'hFFFFFFFF, '{32'h0, 1'b0}},
		'{ROW_PIX, '0, '0, 32'h00000000, '{32'h0, 1'b0}},
		'{ROW_PIX, '0, '0, 32'hA5A5A5A5, '{32'h0, 1'b0}},
		'{ROW_PIX, '0, '0, 32'h5A5A5A5A, '{32'h0, 1'b0}},
		'{ROW_PIX, '0, '0, 32'hFEFDFCFB, '{32'h0, 1'b0}},
		'{ROW_PIX, '0, '0, 32'h10203040, '{32'h0, 1'b0}},
		// zero sizes read as 1x1
		'{ROW_CFG, mbd_pkg::REG_SRC_WIDTH, 16'd0, 32'h0, '{32'h0, 1'b0}},
		'{ROW_CFG, mbd_pkg::REG_SRC_HEIGHT, 16'd0, 32'h0, '{32'h0, 1'b0}},
		'{ROW_PIX_NONE, '0, '0, 32'h12345678, '{32'h0, 1'b0}},
		// oversized width clamps, height 1 is not halved
		'{ROW_CFG, mbd_pkg::REG_SRC_WIDTH, 16'hFFFF, 32'h0, '{32'h0, 1'b0}},
		'{ROW_CFG, mbd_pkg::REG_SRC_HEIGHT, 16'd1, 32'h0, '{32'h0, 1'b0}},
		'{ROW_PIX_NONE, '0, '0, 32'h00FF00FF, '{32'h0, 1'b0}},
		'{ROW_PIX_OUT, '0, '0, 32'h000001FE, '{32'h007F00FE, 1'b0}},
		// width 1, tallest height
		'{ROW_CFG, mbd_pkg::REG_SRC_WIDTH, 16'd1, 32'h0, '{32'h0, 1'b0}},
		'{ROW_CFG, mbd_pkg::REG_SRC_HEIGHT, 16'hFFFF, 32'h0, '{32'h0, 1'b0}},
		'{ROW_PIX, '0, '0, 32'h80FF7F01, '{32'h0, 1'b0}},
		'{ROW_PIX, '0, '0, 32'h7F00FF02, '{32'h0, 1'b0}}
	};

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           s_tvalid  = 1'b0;
	logic                           s_tready;
	logic [31:0]                    s_tdata   = '0;
	logic                           m_tvalid;
	logic                           m_tready  = 1'b0;
	logic [31:0]                    m_tdata;
	logic                           m_tlast;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [mbd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [mbd_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

	mipmap_box_downsample_core DUT (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// mirror of the block's registers and running sums
	logic [mbd_pkg::WREG_W-1:0] width_reg;
	logic [mbd_pkg::HREG_W-1:0] height_reg;
	int unsigned col_sum [mbd_pkg::SUM_DEPTH][mbd_pkg::NUM_LANES];
	int unsigned row_acc [mbd_pkg::NUM_LANES];
	int unsigned next_col, next_row;

	mip_px_t pending_mip [$];
	int      pixels_in, mips_out, reg_writes, mismatches, idle_cycles;
	bit      quiet, squeeze;

	function automatic int gap_len();
		int r;
		if (quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	function automatic logic [31:0] pick_pixel();
		logic [mbd_pkg::NUM_LANES-1:0][mbd_pkg::CH_W-1:0] p;
		case ($urandom_range(0, 7))
			0: p = '1;
			1: p = '0;
			2: begin
				for (int c = 0; c < mbd_pkg::NUM_LANES; c++)
					p[c] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			end
			default: p = $urandom;
		endcase
		return p;
	endfunction

	function automatic void restart_frame();
		next_col = 0;
		next_row = 0;
		for (int c = 0; c < mbd_pkg::NUM_LANES; c++) row_acc[c] = 0;
	endfunction

	function automatic void apply_reg(logic [mbd_pkg::CFG_IDX_W-1:0] idx,
			logic [mbd_pkg::CFG_DATA_W-1:0] val);
		if (idx == mbd_pkg::REG_SRC_WIDTH) begin
			width_reg = val[mbd_pkg::WREG_W-1:0];
			restart_frame();
		end else if (idx == mbd_pkg::REG_SRC_HEIGHT) begin
			height_reg = val;
			restart_frame();
		end
	endfunction

	// accumulate one source pixel; hit is set when it closes a block
	function automatic void box_average_step(
			input logic [mbd_pkg::NUM_LANES-1:0][mbd_pkg::CH_W-1:0] px,
			output bit hit, output mip_px_t res);
		int unsigned w, h, mw, mh, cx, ry, oc, orow, cnt;
		bit col_end, row_end;
		w = (width_reg == 0) ? 1 : width_reg;
		if (w > mbd_pkg::MAX_WIDTH) w = mbd_pkg::MAX_WIDTH;
		h = (height_reg == 0) ? 1 : height_reg;
		mw = (w > 1) ? w / 2 : 1;
		mh = (h > 1) ? h / 2 : 1;
		cx = (next_col >= w) ? w - 1 : next_col;
		ry = (next_row >= h) ? h - 1 : next_row;
		oc = (cx / 2 > mw - 1) ? mw - 1 : cx / 2;
		orow = (ry / 2 > mh - 1) ? mh - 1 : ry / 2;
		hit = 1'b0;
		res = '0;
		for (int c = 0; c < mbd_pkg::NUM_LANES; c++) row_acc[c] += px[c];
		col_end = (cx == w - 1) || ((cx % 2 == 1) && (cx / 2 < mw - 1));
		row_end = (ry == h - 1) || ((ry % 2 == 1) && (ry / 2 < mh - 1));
		if (col_end) begin
			for (int c = 0; c < mbd_pkg::NUM_LANES; c++) begin
				col_sum[oc][c] = (ry == 2 * orow) ? row_acc[c] : col_sum[oc][c] + row_acc[c];
				row_acc[c] = 0;
			end
			if (row_end && !(w == 1 && h == 1)) begin
				// odd trailing column or row folds a third pixel into the block
				cnt = ((w == 1) ? 1 : (oc == mw - 1 && w % 2 == 1) ? 3 : 2) *
				      ((h == 1) ? 1 : (orow == mh - 1 && h % 2 == 1) ? 3 : 2);
				for (int c = 0; c < mbd_pkg::NUM_LANES; c++)
					res.px[c] = 8'(col_sum[oc][c] / cnt);
				res.last = (oc == mw - 1) && (orow == mh - 1);
				hit = 1'b1;
			end
		end
		cx++;
		if (cx >= w) begin
			cx = 0;
			ry++;
			if (ry >= h) ry = 0;
		end
		next_col = cx;
		next_row = ry;
	endfunction

	task automatic send_pixel(input logic [31:0] d, input plan_kind_t kind, input mip_px_t typed);
		int      g;
		bit      hit;
		mip_px_t got;
		g = gap_len();
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pixels_in++;
		box_average_step(d, hit, got);
		if (kind == ROW_PIX_OUT) pending_mip.push_back(typed);
		else if (kind == ROW_PIX && hit) pending_mip.push_back(got);
	endtask

	// registers only change with nothing in flight
	task automatic write_reg(input logic [mbd_pkg::CFG_IDX_W-1:0] idx,
			input logic [mbd_pkg::CFG_DATA_W-1:0] val);
		s_tvalid <= 1'b0;
		while (pending_mip.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		apply_reg(idx, val);
		reg_writes++;
	endtask

	initial begin : receiver
		int n;
		wait (arst_n === 1'b1);
		forever begin
			if (squeeze) begin
				squeeze = 1'b0;
				m_tready <= 1'b0;
				for (n = 0; n < LONG_STALL; n++) @(posedge clk);
			end else begin
				n = gap_len();
				if (n > 0) begin
					m_tready <= 1'b0;
					repeat (n) @(posedge clk);
				end
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		mip_px_t want;
		if (arst_n && m_tvalid && m_tready) begin
			mips_out++;
			if (pending_mip.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected mip beat %h last %b", m_tdata, m_tlast);
			end else begin
				want = pending_mip.pop_front();
				if (want.px !== m_tdata || want.last !== m_tlast) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mip beat %0d: expected %h last %b, got %h last %b",
							mips_out, want.px, want.last, m_tdata, m_tlast);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("no beat for %0d cycles, %0d mip pixels outstanding",
				idle_cycles, pending_mip.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin : stimulus
		int unsigned wv, hv, npix, pick;
		bit          one_reg;
		width_reg  = 1;
		height_reg = 1;
		restart_frame();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NPLAN; i++) begin
			if (PLAN[i].kind == ROW_CFG) write_reg(PLAN[i].idx, PLAN[i].val);
			else send_pixel(PLAN[i].pix, PLAN[i].kind, PLAN[i].want);
		end

		// long output hold-off with the input running flat out
		write_reg(mbd_pkg::REG_SRC_WIDTH, 16'd2);
		write_reg(mbd_pkg::REG_SRC_HEIGHT, 16'd2);
		quiet   = 1'b1;
		squeeze = 1'b1;
		repeat (96) send_pixel(pick_pixel(), ROW_PIX, '0);

		while (pixels_in < ITEMS) begin
			pick    = $urandom_range(0, 19);
			quiet   = ($urandom_range(0, 4) == 0);
			one_reg = 1'b0;
			if (pick == 3)
				write_reg(mbd_pkg::CFG_IDX_W'($urandom_range(FIRST_SPARE_REG, LAST_SPARE_REG)),
					mbd_pkg::CFG_DATA_W'($urandom));
			case (pick)
				0: begin
					case ($urandom_range(0, 3))
						0: wv = 0;
						1: wv = mbd_pkg::MAX_WIDTH;
						2: wv = $urandom_range(mbd_pkg::MAX_WIDTH + 1, 8191);
						default: wv = $urandom_range(mbd_pkg::SUM_DEPTH - 8,
							mbd_pkg::MAX_WIDTH - 1);
					endcase
					hv   = ($urandom_range(0, 3) == 0) ? 0 : 1;
					npix = $urandom_range(8, 48);
				end
				1: begin
					wv   = $urandom_range(1, 6);
					hv   = $urandom_range(0, 1) ? 16'hFFFF : 0;
					npix = $urandom_range(8, 64);
				end
				default: begin
					wv = ($urandom_range(0, 5) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
					one_reg = ($urandom_range(0, 5) == 0);
					hv = one_reg ? ((height_reg == 0) ? 1 : height_reg) : $urandom_range(1, 8);
					npix = wv * hv * $urandom_range(1, 3);
					if (pick == 2) npix = $urandom_range(1, npix);
					if (npix > 240) npix = $urandom_range(8, 240);
				end
			endcase
			// upper data bits fall outside the width register
			write_reg(mbd_pkg::REG_SRC_WIDTH,
				mbd_pkg::CFG_DATA_W'(wv | ($urandom_range(0, 7) << mbd_pkg::WREG_W)));
			if (!one_reg) write_reg(mbd_pkg::REG_SRC_HEIGHT, mbd_pkg::CFG_DATA_W'(hv));
			repeat (npix) send_pixel(pick_pixel(), ROW_PIX, '0);
		end

		s_tvalid <= 1'b0;
		while (pending_mip.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES * 2) @(posedge clk);

		$display("Ran %0d source pixels through %0d register writes; %0d mip pixels compared.",
			pixels_in, reg_writes, mips_out);
		$display("Sizes ranged from 1x1 to clamped 4096 wide and 65535 high, odd and even.");
		if (mismatches == 0 && pending_mip.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
